>>> hdl/efk_pkg.sv
package efk_pkg;

	localparam int MAX_NODES = 64;
	localparam int CAP_BITS  = 16;
	localparam int NODE_W    = $clog2(MAX_NODES);
	localparam int ADDR_W    = 2 * NODE_W;
	localparam int CELLS     = MAX_NODES * MAX_NODES;
	localparam int FLOW_W    = CAP_BITS + 1;
	localparam int RES_W     = CAP_BITS + 2;
	localparam int TOTAL_W   = 22;
	localparam int OP_W      = 2;

	typedef enum logic [OP_W-1:0] {
		OP_ADD = 2'd0,
		OP_RUN = 2'd1,
		OP_CLR = 2'd2,
		OP_NOP = 2'd3
	} op_t;

	typedef enum logic [4:0] {
		S_INIT,
		S_IDLE,
		S_ADD_RD,
		S_ADD_WR,
		S_CLR,
		S_FCLR,
		S_BFS_INIT,
		S_DEQ,
		S_DEQ_W,
		S_SCAN,
		S_TB_P,
		S_TB_A,
		S_TB_R,
		S_TU_P,
		S_TU_A,
		S_TU_W,
		S_TU_B,
		S_RESULT
	} state_t;

endpackage

>>> hdl/max_flow_edmonds_karp.sv
// Edmonds-Karp maximum flow over a 64-node capacity matrix held in block memory.
// After reset the capacity memory, all 4096 cells, is swept to zero, during which
// no item is taken; a clear item repeats that sweep. An add item reads the cell,
// adds with saturation and writes the sum back. A run item first zeroes the flow
// memory; then each breadth-first search enqueues the source and scans one
// 64-entry row per dequeued node through each memory's single read port, until
// the sink is dequeued or the queue is empty, and each augmenting path is walked
// hop by hop, once to find the bottleneck and once to update the flows. A run
// whose source equals its sink answers 0 at once. The single result sits in an
// output register, so add and clear items are taken while it waits.
module max_flow_edmonds_karp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [efk_pkg::OP_W-1:0]        op,
	input  logic [efk_pkg::NODE_W-1:0]      node_a,
	input  logic [efk_pkg::NODE_W-1:0]      node_b,
	input  logic [efk_pkg::CAP_BITS-1:0]    capacity,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [efk_pkg::TOTAL_W-1:0]     flow_total
);
	import efk_pkg::*;

	state_t state_q, state_d;

	logic [ADDR_W-1:0]   sweep_q;
	logic [NODE_W-1:0]   src_q, snk_q, u_q, v_q, n_s1;
	logic [CAP_BITS-1:0] cap_in_q;
	logic [NODE_W:0]     head_q, tail_q, n_q;
	logic                valid_s1, first_q;
	logic [MAX_NODES-1:0] visited_q;
	logic [RES_W-1:0]    extra_q;
	logic [FLOW_W-1:0]   nf_q;
	logic [TOTAL_W-1:0]  total_q;
	logic                out_valid_q;
	logic [TOTAL_W-1:0]  flow_total_q;

	logic                cap_we, flow_we, pred_we, queue_we;
	logic [ADDR_W-1:0]   cap_waddr, cap_raddr, flow_waddr, flow_raddr;
	logic [CAP_BITS-1:0] cap_wdata, cap_rdata;
	logic [FLOW_W-1:0]   flow_wdata, flow_rdata;
	logic [NODE_W-1:0]   pred_waddr, pred_raddr, pred_rdata;
	logic [NODE_W-1:0]   queue_waddr, queue_raddr, queue_wdata, queue_rdata;

	logic                accept;
	logic [CAP_BITS:0]   sat_sum;
	logic signed [RES_W-1:0] resid;
	logic                resid_pos;
	logic [FLOW_W-1:0]   nf;
	logic [TOTAL_W:0]    total_sum;
	logic                out_load;

	efk_ram #(.WIDTH(CAP_BITS), .DEPTH(CELLS)) u_cap (
		.clk(clk), .we(cap_we), .waddr(cap_waddr), .wdata(cap_wdata),
		.raddr(cap_raddr), .rdata(cap_rdata)
	);
	efk_ram #(.WIDTH(FLOW_W), .DEPTH(CELLS)) u_flow (
		.clk(clk), .we(flow_we), .waddr(flow_waddr), .wdata(flow_wdata),
		.raddr(flow_raddr), .rdata(flow_rdata)
	);
	efk_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_pred (
		.clk(clk), .we(pred_we), .waddr(pred_waddr), .wdata(u_q),
		.raddr(pred_raddr), .rdata(pred_rdata)
	);
	efk_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_queue (
		.clk(clk), .we(queue_we), .waddr(queue_waddr), .wdata(queue_wdata),
		.raddr(queue_raddr), .rdata(queue_rdata)
	);

	assign in_stall   = (state_q != S_IDLE);
	assign accept     = in_valid && !in_stall;
	assign out_valid  = out_valid_q;
	assign flow_total = flow_total_q;

	assign sat_sum   = {1'b0, cap_rdata} + {1'b0, cap_in_q};
	assign resid     = $signed({2'b00, cap_rdata}) - $signed({flow_rdata[FLOW_W-1], flow_rdata});
	assign resid_pos = !resid[RES_W-1] && (resid != '0);
	assign nf        = FLOW_W'($signed(flow_rdata) + $signed(extra_q));
	assign total_sum = {1'b0, total_q} + (TOTAL_W+1)'(extra_q);
	assign out_load  = (state_q == S_RESULT) && (!out_valid_q || !out_stall);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_INIT, S_CLR: begin
				if (&sweep_q) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (accept) begin
					unique case (op_t'(op))
						OP_ADD: state_d = S_ADD_RD;
						OP_RUN: state_d = (node_a == node_b) ? S_RESULT : S_FCLR;
						OP_CLR: state_d = S_CLR;
						OP_NOP: state_d = S_IDLE;
					endcase
				end
			end
			S_ADD_RD:   state_d = S_ADD_WR;
			S_ADD_WR:   state_d = S_IDLE;
			S_FCLR: begin
				if (&sweep_q) state_d = S_BFS_INIT;
			end
			S_BFS_INIT: state_d = S_DEQ;
			S_DEQ:      state_d = (head_q == tail_q) ? S_RESULT : S_DEQ_W;
			S_DEQ_W:    state_d = (queue_rdata == snk_q) ? S_TB_P : S_SCAN;
			S_SCAN: begin
				if (valid_s1 && (&n_s1)) state_d = S_DEQ;
			end
			S_TB_P:     state_d = S_TB_A;
			S_TB_A:     state_d = S_TB_R;
			S_TB_R:     state_d = (u_q == src_q) ? S_TU_P : S_TB_P;
			S_TU_P:     state_d = S_TU_A;
			S_TU_A:     state_d = S_TU_W;
			S_TU_W:     state_d = S_TU_B;
			S_TU_B:     state_d = (u_q == src_q) ? S_BFS_INIT : S_TU_P;
			S_RESULT: begin
				if (out_load) state_d = S_IDLE;
			end
			default:    state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cap_we      = 1'b0;
		cap_waddr   = sweep_q;
		cap_wdata   = '0;
		cap_raddr   = {u_q, n_q[NODE_W-1:0]};
		flow_we     = 1'b0;
		flow_waddr  = sweep_q;
		flow_wdata  = '0;
		flow_raddr  = {u_q, n_q[NODE_W-1:0]};
		pred_we     = 1'b0;
		pred_waddr  = n_s1;
		pred_raddr  = v_q;
		queue_we    = 1'b0;
		queue_waddr = tail_q[NODE_W-1:0];
		queue_wdata = n_s1;
		queue_raddr = head_q[NODE_W-1:0];
		unique case (state_q)
			S_INIT, S_CLR: begin
				cap_we = 1'b1;
			end
			S_ADD_RD: begin
				cap_raddr = {src_q, snk_q};
			end
			S_ADD_WR: begin
				cap_we    = 1'b1;
				cap_waddr = {src_q, snk_q};
				cap_wdata = sat_sum[CAP_BITS] ? '1 : sat_sum[CAP_BITS-1:0];
			end
			S_FCLR: begin
				flow_we = 1'b1;
			end
			S_BFS_INIT: begin
				queue_we    = 1'b1;
				queue_waddr = '0;
				queue_wdata = src_q;
			end
			S_SCAN: begin
				if (valid_s1 && !visited_q[n_s1] && resid_pos) begin
					pred_we  = 1'b1;
					queue_we = 1'b1;
				end
			end
			S_TB_A, S_TU_A: begin
				cap_raddr  = {pred_rdata, v_q};
				flow_raddr = {pred_rdata, v_q};
			end
			S_TU_W: begin
				flow_we    = 1'b1;
				flow_waddr = {u_q, v_q};
				flow_wdata = nf;
			end
			S_TU_B: begin
				flow_we    = 1'b1;
				flow_waddr = {v_q, u_q};
				flow_wdata = FLOW_W'(-$signed(nf_q));
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			sweep_q     <= '0;
			out_valid_q <= 1'b0;
			head_q      <= '0;
			tail_q      <= '0;
			n_q         <= '0;
			valid_s1    <= 1'b0;
			visited_q   <= '0;
			total_q     <= '0;
			first_q     <= 1'b1;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			valid_s1 <= (state_q == S_SCAN) && !n_q[NODE_W];
			unique case (state_q)
				S_INIT, S_CLR, S_FCLR: begin
					sweep_q <= sweep_q + 1'b1;
				end
				S_IDLE: begin
					sweep_q <= '0;
					total_q <= '0;
				end
				S_BFS_INIT: begin
					visited_q <= MAX_NODES'(1) << src_q;
					head_q    <= '0;
					tail_q    <= (NODE_W+1)'(1);
					first_q   <= 1'b1;
				end
				S_DEQ: begin
					if (head_q != tail_q) head_q <= head_q + 1'b1;
				end
				S_DEQ_W: begin
					u_q <= queue_rdata;
					v_q <= snk_q;
					n_q <= '0;
				end
				S_SCAN: begin
					if (!n_q[NODE_W]) begin
						n_q  <= n_q + 1'b1;
						n_s1 <= n_q[NODE_W-1:0];
					end
					if (valid_s1 && !visited_q[n_s1] && resid_pos) begin
						visited_q[n_s1] <= 1'b1;
						tail_q          <= tail_q + 1'b1;
					end
				end
				S_TB_A, S_TU_A: begin
					u_q <= pred_rdata;
				end
				S_TB_R: begin
					if (first_q || (RES_W'(resid) < extra_q)) extra_q <= RES_W'(resid);
					first_q <= 1'b0;
					v_q     <= (u_q == src_q) ? snk_q : u_q;
				end
				S_TU_W: begin
					nf_q <= nf;
				end
				S_TU_B: begin
					v_q <= u_q;
					if (u_q == src_q) begin
						total_q <= total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			src_q    <= node_a;
			snk_q    <= node_b;
			cap_in_q <= capacity;
		end
		if (out_load) begin
			flow_total_q <= total_q;
		end
	end

endmodule

>>> hdl/efk_ram.sv
module efk_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> dv/tb_max_flow_edmonds_karp.sv
`timescale 1ns / 1ps

module tb_max_flow_edmonds_karp;
	import efk_pkg::*;

	localparam int WATCHDOG_LIMIT = 300000;
	localparam int DRAIN_CYCLES   = 200;
	localparam int RANDOM_ITEMS   = 1250;

	class flow_scoreboard;
		bit [CAP_BITS-1:0] cap_mat [MAX_NODES][MAX_NODES];
		int                flow_mat [MAX_NODES][MAX_NODES];
		bit [TOTAL_W-1:0]  totals_due [$];
		int                errors;

		function void clear_caps();
			foreach (cap_mat[i, j]) begin
				cap_mat[i][j] = '0;
			end
		endfunction

		function bit find_path(int src, int snk, ref int pred [MAX_NODES]);
			int q [MAX_NODES];
			int head, tail, u;
			head = 0;
			tail = 0;
			for (int n = 0; n < MAX_NODES; n++) begin
				pred[n] = -1;
			end
			pred[src] = src;
			q[tail++] = src;
			while (head < tail) begin
				u = q[head++];
				if (u == snk) begin
					break;
				end
				for (int n = 0; n < MAX_NODES; n++) begin
					if (pred[n] < 0 && int'(cap_mat[u][n]) - flow_mat[u][n] > 0) begin
						pred[n] = u;
						if (tail < MAX_NODES) begin
							q[tail++] = n;
						end
					end
				end
			end
			return pred[snk] >= 0;
		endfunction

		function longint max_flow(int src, int snk);
			int     pred [MAX_NODES];
			longint total;
			int     extra, v, u, r;
			total = 0;
			foreach (flow_mat[i, j]) begin
				flow_mat[i][j] = 0;
			end
			if (src == snk) begin
				return 0;
			end
			while (find_path(src, snk, pred)) begin
				extra = -1;
				v = snk;
				while (v != src) begin
					u = pred[v];
					r = int'(cap_mat[u][v]) - flow_mat[u][v];
					if (extra < 0 || r < extra) begin
						extra = r;
					end
					v = u;
				end
				v = snk;
				while (v != src) begin
					u = pred[v];
					flow_mat[u][v] += extra;
					flow_mat[v][u] = -flow_mat[u][v];
					v = u;
				end
				total += extra;
			end
			return total;
		endfunction

		function void note_input(op_t op, int a, int b, bit [CAP_BITS-1:0] amount);
			int     sum;
			longint total;
			case (op)
				OP_ADD: begin
					sum = int'(cap_mat[a][b]) + int'(amount);
					cap_mat[a][b] = (sum > 65535) ? '1 : sum[CAP_BITS-1:0];
				end
				OP_RUN: begin
					total = max_flow(a, b);
					if (total > 64'd4194303) begin
						total = 4194303;
					end
					totals_due.insert(totals_due.size(), total[TOTAL_W-1:0]);
				end
				OP_CLR: clear_caps();
				default: ;
			endcase
		endfunction

		function void check_result(bit [TOTAL_W-1:0] got);
			bit [TOTAL_W-1:0] want;
			if (totals_due.size() == 0) begin
				$error("flow_total: unexpected result %0d", got);
				errors++;
				return;
			end
			want = totals_due.pop_front();
			if (got !== want) begin
				$error("flow_total: expected %0d, actual %0d", want, got);
				errors++;
			end
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic [OP_W-1:0]     op;
	logic [NODE_W-1:0]   node_a;
	logic [NODE_W-1:0]   node_b;
	logic [CAP_BITS-1:0] capacity;
	logic                out_valid;
	logic                out_stall;
	logic [TOTAL_W-1:0]  flow_total;

	flow_scoreboard sb;
	int             send_idle_pct;
	int             recv_idle_pct;
	int             quiet_cycles;
	int             items_sent;

	max_flow_edmonds_karp u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.op         (op),
		.node_a     (node_a),
		.node_b     (node_b),
		.capacity   (capacity),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.flow_total (flow_total)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	always @(posedge clk) begin
		bit took;
		took = 1'b0;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				took = 1'b1;
			end
			if (out_valid && !out_stall) begin
				took = 1'b1;
				sb.check_result(flow_total);
			end
			quiet_cycles = took ? 0 : quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("tb_max_flow_edmonds_karp: done, errors");
				$finish;
			end
		end
		out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	task automatic send_item(op_t o, int a, int b, bit [CAP_BITS-1:0] amount);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		op       <= o;
		node_a   <= a[NODE_W-1:0];
		node_b   <= b[NODE_W-1:0];
		capacity <= amount;
		do begin
			@(posedge clk);
		end while (in_stall);
		sb.note_input(o, a, b, amount);
		items_sent++;
	endtask

	function automatic bit [CAP_BITS-1:0] pick_capacity();
		case ($urandom_range(3))
			0: return CAP_BITS'($urandom_range(15));
			1: return CAP_BITS'($urandom_range(65535, 49152));
			default: return CAP_BITS'($urandom_range(65535));
		endcase
	endfunction

	task automatic send_graph();
		int base, span, a, b;
		if ($urandom_range(9) < 7) begin
			send_item(OP_CLR, $urandom_range(63), $urandom_range(63), CAP_BITS'($urandom));
		end
		base = $urandom_range(56);
		span = $urandom_range(7, 1);
		repeat ($urandom_range(12, 1)) begin
			case ($urandom_range(19))
				0: send_item(OP_NOP, $urandom_range(63), $urandom_range(63),
						CAP_BITS'($urandom));
				1: send_item(OP_ADD, $urandom_range(63), $urandom_range(63), pick_capacity());
				default: send_item(OP_ADD, base + $urandom_range(span),
						base + $urandom_range(span), pick_capacity());
			endcase
		end
		repeat ($urandom_range(2, 1)) begin
			a = base + $urandom_range(span);
			b = ($urandom_range(9) == 0) ? $urandom_range(63) : base + $urandom_range(span);
			send_item(OP_RUN, a, b, CAP_BITS'($urandom));
		end
	endtask

	initial begin
		sb = new();
		sb.clear_caps();
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		op            = OP_NOP;
		node_a        = '0;
		node_b        = '0;
		capacity      = '0;
		quiet_cycles  = 0;
		items_sent    = 0;
		send_idle_pct = 11;
		recv_idle_pct = 66;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(OP_ADD, 0, 1, 16'hFFFF);
		send_item(OP_ADD, 0, 1, 16'd5);
		send_item(OP_ADD, 1, 63, 16'd40000);
		send_item(OP_ADD, 63, 2, 16'hFFFF);
		send_item(OP_ADD, 0, 2, 16'd1);
		send_item(OP_ADD, 2, 2, 16'd77);
		send_item(OP_RUN, 0, 63, 16'd0);
		send_item(OP_RUN, 5, 5, 16'hFFFF);
		send_item(OP_RUN, 63, 63, 16'd0);
		send_item(OP_RUN, 63, 0, 16'd0);
		send_item(OP_NOP, 63, 63, 16'hFFFF);
		send_item(OP_RUN, 0, 2, 16'd0);
		send_item(OP_ADD, 42, 21, 16'hAAAA);
		send_item(OP_ADD, 21, 42, 16'h5555);
		send_item(OP_RUN, 21, 42, 16'd0);
		send_item(OP_RUN, 0, 1, 16'd0);
		send_item(OP_CLR, 63, 63, 16'hFFFF);
		send_item(OP_RUN, 0, 1, 16'd0);
		send_item(OP_ADD, 2, 3, 16'h5555);
		send_item(OP_RUN, 2, 3, 16'd0);

		items_sent = 0;
		while (items_sent < RANDOM_ITEMS) begin
			if (items_sent < RANDOM_ITEMS / 3) begin
				send_idle_pct = 11;
				recv_idle_pct = 66;
			end else if (items_sent < 2 * RANDOM_ITEMS / 3) begin
				send_idle_pct = 66;
				recv_idle_pct = 11;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			send_graph();
		end
		in_valid <= 1'b0;

		while (sb.totals_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0) begin
			$display("tb_max_flow_edmonds_karp: done, clean");
		end else begin
			$display("tb_max_flow_edmonds_karp: done, errors");
		end
		$finish;
	end

endmodule
